// File: sv/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on the rising clock, idle during reset
`define OWT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, sampled on the rising clock, idle during reset
`define OWT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: sv/owtsd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// owtsd_pkg
// Shared constants, types and the 1-Wire CRC8 byte update for the decoder.
// ----------------------------------------------------------------------------
package owtsd_pkg;

  localparam int unsigned PAD_BYTES  = 9;
  localparam int unsigned IDX_W      = 4;
  localparam int unsigned OFFSET_W   = 12;
  localparam int unsigned TEMP_W     = 16;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 12;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_SENSOR_KIND = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET      = 1'b1;

  // sensor kinds
  localparam logic KIND_12BIT = 1'b0;
  localparam logic KIND_9BIT  = 1'b1;

  localparam logic [7:0] CRC_POLY   = 8'h8C;
  localparam logic [7:0] MSB_NEG    = 8'hFF;

  // completed frame handed from the byte collector to the result stage
  typedef struct packed {
    logic       crc_good;
    logic [7:0] temp_lo;
    logic [7:0] temp_hi;
    logic [7:0] count_remain;
  } frame_evt_t;

  // reflected crc8, one byte, lsb first
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                           input logic [7:0] data_in);
    logic [7:0] c;
    logic [7:0] d;
    logic       mix;
    c = crc_in;
    d = data_in;
    for (int k = 0; k < 8; k++) begin
      mix = c[0] ^ d[0];
      c   = {1'b0, c[7:1]};
      if (mix) begin
        c = c ^ CRC_POLY;
      end
      d = {1'b0, d[7:1]};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: sv/owtsd_frame.sv
`default_nettype none
// ----------------------------------------------------------------------------
// owtsd_frame
// Byte collector: counts scratchpad bytes, runs the CRC and keeps the
// temperature and count-remain bytes; registers one event per full frame.
// ----------------------------------------------------------------------------
module owtsd_frame (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  wire  [7:0]           pad_byte,
  input  wire                  frame_start,
  output logic                 evt_valid,
  input  wire                  evt_ready,
  output owtsd_pkg::frame_evt_t evt
);
  import owtsd_pkg::*;

  logic [IDX_W-1:0] idx_r, idx_nxt, idx_eff;
  logic [7:0]       crc_r, crc_nxt, crc_eff;
  logic [7:0]       lo_r, lo_nxt;
  logic [7:0]       hi_r, hi_nxt;
  logic [7:0]       cr_r, cr_nxt;
  logic             evt_valid_r, evt_valid_nxt;
  frame_evt_t       evt_r, evt_nxt;
  logic             take;
  logic             done;

  assign in_ready  = !evt_valid_r || evt_ready;
  assign evt_valid = evt_valid_r;
  assign evt       = evt_r;

  // frame start restarts count and crc before the byte is taken
  assign idx_eff = frame_start ? '0 : idx_r;
  assign crc_eff = frame_start ? '0 : crc_r;
  assign take    = in_valid && in_ready && (idx_eff < IDX_W'(PAD_BYTES));
  assign done    = take && (idx_eff == IDX_W'(PAD_BYTES - 1));

  always_comb begin
    idx_nxt       = idx_r;
    crc_nxt       = crc_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    cr_nxt        = cr_r;
    evt_nxt       = evt_r;
    evt_valid_nxt = evt_valid_r;
    if (take) begin
      crc_nxt = crc8_byte(crc_eff, pad_byte);
      idx_nxt = idx_eff + IDX_W'(1);
      if (idx_eff == IDX_W'(0)) begin
        lo_nxt = pad_byte;
      end
      if (idx_eff == IDX_W'(1)) begin
        hi_nxt = pad_byte;
      end
      if (idx_eff == IDX_W'(6)) begin
        cr_nxt = pad_byte;
      end
    end
    if (in_ready) begin
      evt_valid_nxt = done;
    end
    if (done) begin
      // stored bytes are final by the ninth byte, which is the crc itself
      evt_nxt.crc_good     = (crc_nxt == 8'h00);
      evt_nxt.temp_lo      = lo_r;
      evt_nxt.temp_hi      = hi_r;
      evt_nxt.count_remain = cr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      crc_r       <= '0;
      lo_r        <= '0;
      hi_r        <= '0;
      cr_r        <= '0;
      evt_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      crc_r       <= crc_nxt;
      lo_r        <= lo_nxt;
      hi_r        <= hi_nxt;
      cr_r        <= cr_nxt;
      evt_valid_r <= evt_valid_nxt;
    end
    evt_r <= evt_nxt;
  end

endmodule

`default_nettype wire

// File: sv/owtsd_result.sv
`default_nettype none
// ----------------------------------------------------------------------------
// owtsd_result
// Result stage: decodes the frame per sensor kind, adds the offset,
// saturates to 16 bits, zeroes it on a bad CRC and holds it in the output register.
// ----------------------------------------------------------------------------
module owtsd_result (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  evt_valid,
  output logic                                 evt_ready,
  input  wire  owtsd_pkg::frame_evt_t          evt,
  input  wire                                  sensor_kind,
  input  wire  [owtsd_pkg::OFFSET_W-1:0]       offset,
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output logic [owtsd_pkg::TEMP_W-1:0]         out_temp,
  output logic                                 out_good
);
  import owtsd_pkg::*;

  localparam int unsigned SUM_W = TEMP_W + 2;

  logic              out_valid_r, out_valid_nxt;
  logic [TEMP_W-1:0] temp_r, temp_nxt;
  logic              good_r, good_nxt;
  logic [9:0]        half;
  logic [SUM_W-1:0]  t12, t9, traw, off_ext, sum;
  logic [TEMP_W-1:0] sat;

  assign evt_ready = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_temp  = temp_r;
  assign out_good  = good_r;

  always_comb begin
    t12 = {{(SUM_W - 16){evt.temp_hi[7]}}, evt.temp_hi, evt.temp_lo};
    // half degrees, bit 0 dropped; msb all ones means lsb - 256
    if (evt.temp_hi == MSB_NEG) begin
      half = {2'b11, evt.temp_lo[7:1], 1'b0};
    end else begin
      half = {2'b00, evt.temp_lo[7:1], 1'b0};
    end
    // half*8 - 4 + 16 - count_remain
    t9 = {{(SUM_W - 13){half[9]}}, half, 3'b000} + SUM_W'(12)
         - {{(SUM_W - 8){1'b0}}, evt.count_remain};
    traw    = (sensor_kind == KIND_9BIT) ? t9 : t12;
    off_ext = {{(SUM_W - OFFSET_W){offset[OFFSET_W-1]}}, offset};
    sum     = traw + off_ext;
    priority if (!sum[SUM_W-1] && (sum[SUM_W-2:TEMP_W-1] != '0)) begin
      sat = {1'b0, {(TEMP_W - 1){1'b1}}};
    end else if (sum[SUM_W-1] && (sum[SUM_W-2:TEMP_W-1] != '1)) begin
      sat = {1'b1, {(TEMP_W - 1){1'b0}}};
    end else begin
      sat = sum[TEMP_W-1:0];
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    temp_nxt      = temp_r;
    good_nxt      = good_r;
    if (evt_ready) begin
      out_valid_nxt = evt_valid;
      if (evt_valid) begin
        good_nxt = evt.crc_good;
        temp_nxt = evt.crc_good ? sat : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    temp_r <= temp_nxt;
    good_r <= good_nxt;
  end

endmodule

`default_nettype wire

// File: sv/onewire_temp_scratchpad_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// onewire_temp_scratchpad_decoder
// Decodes the nine scratchpad bytes of a 1-Wire temperature sensor into a
// temperature in 1/16 degC with a CRC-good flag.
// ----------------------------------------------------------------------------
//  channel | direction | tdata                        | tuser
//  in_     | slave     | [7:0] pad_byte               | frame_start
//  out_    | master    | [15:0] temperature_sixteenths| crc_good
//  cfg_    | write     | [11:0] register value        | (index on cfg_index)
//
// one byte per cycle is taken while in_tready is high; a result leaves after the ninth
// byte through the frame event register and then the result register.
// reset (synchronous) clears count, crc, stored bytes and both valid flags.
// in_tready drops only while both the frame event and the result are held
// by a stalled out_tready.
// ----------------------------------------------------------------------------
module onewire_temp_scratchpad_decoder (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_tvalid,
  output logic                                 in_tready,
  input  wire  [7:0]                           in_tdata,   // [7:0] pad_byte
  input  wire                                  in_tuser,   // [0] frame_start
  output logic                                 out_tvalid,
  input  wire                                  out_tready,
  output logic [owtsd_pkg::TEMP_W-1:0]         out_tdata,  // [15:0] temperature_sixteenths
  output logic                                 out_tuser,  // [0] crc_good
  input  wire                                  cfg_we,
  input  wire  [owtsd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [owtsd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import owtsd_pkg::*;

  logic                kind_r, kind_nxt;
  logic [OFFSET_W-1:0] offset_r, offset_nxt;
  logic                evt_valid;
  logic                evt_ready;
  frame_evt_t          evt;

  always_comb begin
    kind_nxt   = kind_r;
    offset_nxt = offset_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_SENSOR_KIND: kind_nxt   = cfg_wdata[0];
        REG_OFFSET:      offset_nxt = cfg_wdata[OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r   <= KIND_12BIT;
      offset_r <= '0;
    end else begin
      kind_r   <= kind_nxt;
      offset_r <= offset_nxt;
    end
  end

  owtsd_frame u_frame (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .pad_byte    (in_tdata),
    .frame_start (in_tuser),
    .evt_valid   (evt_valid),
    .evt_ready   (evt_ready),
    .evt         (evt)
  );

  owtsd_result u_result (
    .clk         (clk),
    .rst_n       (rst_n),
    .evt_valid   (evt_valid),
    .evt_ready   (evt_ready),
    .evt         (evt),
    .sensor_kind (kind_r),
    .offset      (offset_r),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_temp    (out_tdata),
    .out_good    (out_tuser)
  );

endmodule

`default_nettype wire

// File: sv/owtsd_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// owtsd_checker
// Port-level checks on the decoder, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module owtsd_checker (
  input wire                              clk,
  input wire                              rst_n,
  input wire                              in_tvalid,
  input wire                              in_tready,
  input wire                              out_tvalid,
  input wire                              out_tready,
  input wire [owtsd_pkg::TEMP_W-1:0]      out_tdata,
  input wire                              out_tuser
);
  import owtsd_pkg::*;

  wire out_stall = out_tvalid && !out_tready;

  // a stalled result holds
  `OWT_ASSERT_NXT(a_out_hold, clk, rst_n, out_stall, out_tvalid && $stable({out_tdata, out_tuser}))

  // a bad crc forces the temperature to zero
  `OWT_ASSERT_IMP(a_bad_crc_zero, clk, rst_n, out_tvalid && !out_tuser, out_tdata == '0)

  // a new result follows an input transaction through the event and result registers
  `OWT_ASSERT_IMP(a_out_has_cause, clk, rst_n, $rose(out_tvalid), $past(in_tvalid && in_tready, 2))

  // input is never blocked while the output can move
  `OWT_ASSERT_IMP(a_ready_when_free, clk, rst_n, !out_tvalid || out_tready, in_tready)

endmodule

bind onewire_temp_scratchpad_decoder owtsd_checker u_owtsd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Feeds scratchpad byte frames to the 1-Wire temperature decoder under both
// sensor kinds and several calibration offsets. A local decoder predicts
// each reading, and every reading that leaves the block is checked against it.
// ----------------------------------------------------------------------------
module testbench;
  import owtsd_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 6;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temp;
    logic                     good;
  } reading_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata = 8'h00;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [TEMP_W-1:0]     out_tdata;
  logic                  out_tuser;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_SENSOR_KIND;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // local copy of the decoder state and settings
  logic                       cur_kind = KIND_12BIT;
  logic signed [OFFSET_W-1:0] cur_offset = '0;
  int                         frame_pos = 0;
  logic [7:0]                 run_crc = 8'h00;
  logic [7:0]                 lsb_byte = 8'h00;
  logic [7:0]                 msb_byte = 8'h00;
  logic [7:0]                 remain_byte = 8'h00;

  reading_t expected_readings[$];
  int       error_count = 0;
  int       bytes_sent = 0;
  int       tx_idle_pct = 0;
  int       rx_idle_pct = 0;
  int       hold_req = 0;
  int       hold_left = 0;
  int       quiet_cycles = 0;

  onewire_temp_scratchpad_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [7:0] pad_byte
    .in_tuser   (in_tuser),    // [0] frame_start
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // [15:0] temperature_sixteenths
    .out_tuser  (out_tuser),   // [0] crc_good
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // xor the byte in first, then shift it through: same as bit-serial reflected crc
  function automatic logic [7:0] dallas_crc8(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] c;
    c = acc ^ b;
    repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    return c;
  endfunction

  task automatic take_pad_byte(input logic [7:0] b, input logic fs);
    reading_t                 r;
    logic signed [TEMP_W-1:0] word;
    int                       t;
    int                       half;
    int                       remain;
    if (fs) begin
      frame_pos = 0;
      run_crc   = 8'h00;
    end
    if (frame_pos < PAD_BYTES) begin
      run_crc = dallas_crc8(run_crc, b);
      case (frame_pos)
        0: lsb_byte    = b;
        1: msb_byte    = b;
        6: remain_byte = b;
        default: ;
      endcase
      frame_pos++;
      if (frame_pos == PAD_BYTES) begin
        if (cur_kind == KIND_12BIT) begin
          word = {msb_byte, lsb_byte};
          t    = int'(word);
        end else begin
          half   = int'(lsb_byte & 8'hFE);
          remain = int'(remain_byte);
          if (msb_byte == MSB_NEG) begin
            half = half - 256;
          end
          t = half * 8 - 4 + (16 - remain);
        end
        t = t + int'(cur_offset);
        if (t > 32767) t = 32767;
        if (t < -32768) t = -32768;
        r.good = (run_crc == 8'h00);
        r.temp = r.good ? t[TEMP_W-1:0] : '0;
        expected_readings.push_back(r);
      end
    end
  endtask

  task automatic send_pad_byte(input logic [7:0] b, input logic fs);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= fs;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    take_pad_byte(b, fs);
    bytes_sent++;
  endtask

  // nine bytes with temperature and count-remain in place, crc last
  task automatic send_frame(input logic [7:0] lo, input logic [7:0] hi,
                            input logic [7:0] remain, input logic crc_ok,
                            input logic mark_start);
    logic [7:0] pad [PAD_BYTES];
    logic [7:0] acc;
    acc = 8'h00;
    for (int i = 0; i < PAD_BYTES - 1; i++) begin
      pad[i] = 8'($urandom);
    end
    pad[0] = lo;
    pad[1] = hi;
    pad[6] = remain;
    for (int i = 0; i < PAD_BYTES - 1; i++) begin
      acc = dallas_crc8(acc, pad[i]);
    end
    pad[PAD_BYTES-1] = crc_ok ? acc : acc ^ 8'($urandom_range(1, 255));
    for (int i = 0; i < PAD_BYTES; i++) begin
      send_pad_byte(pad[i], (i == 0) && mark_start);
    end
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_setting(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_SENSOR_KIND) begin
      cur_kind = value[0];
    end else begin
      cur_offset = value;
    end
    @(posedge clk);
  endtask

  task automatic test_first_frame_without_start();
    write_setting(REG_SENSOR_KIND, CFG_DATA_W'(KIND_12BIT));
    write_setting(REG_OFFSET, 12'h000);
    send_frame(8'h91, 8'h01, 8'h0C, 1'b1, 1'b0);
    // bytes past the ninth are dropped until the next frame start
    send_pad_byte(8'($urandom), 1'b0);
    send_pad_byte(8'($urandom), 1'b0);
  endtask

  task automatic test_restart_mid_frame();
    send_pad_byte(8'h55, 1'b1);
    for (int i = 0; i < 3; i++) begin
      send_pad_byte(8'($urandom), 1'b0);
    end
    send_frame(8'h5E, 8'hFF, 8'h0C, 1'b1, 1'b1);
    send_frame(8'hA2, 8'h00, 8'h0C, 1'b0, 1'b1);
    wait_idle();
  endtask

  task automatic test_saturation();
    write_setting(REG_OFFSET, 12'h7FF);
    send_frame(8'hFF, 8'h7F, 8'h00, 1'b1, 1'b1);
    wait_idle();
    write_setting(REG_OFFSET, 12'h800);
    send_frame(8'h00, 8'h80, 8'h00, 1'b1, 1'b1);
    send_frame(8'h00, 8'h80, 8'h00, 1'b0, 1'b1);
    wait_idle();
  endtask

  task automatic test_half_degree();
    write_setting(REG_SENSOR_KIND, CFG_DATA_W'(KIND_9BIT));
    write_setting(REG_OFFSET, 12'h000);
    // negative zero lsb, oversized count-remain, msb other than sign ignored
    send_frame(8'h00, 8'hFF, 8'h0C, 1'b1, 1'b1);
    send_frame(8'hFF, 8'h00, 8'hFF, 1'b1, 1'b1);
    send_frame(8'h33, 8'h5A, 8'h00, 1'b1, 1'b1);
    send_frame(8'hFF, 8'hFF, 8'h10, 1'b1, 1'b1);
    wait_idle();
  endtask

  task automatic test_random_frames(input logic kind, input logic [CFG_DATA_W-1:0] offset,
                                    input int n_bytes);
    logic [7:0] lo;
    logic [7:0] hi;
    logic [7:0] remain;
    int         stop_at;
    write_setting(REG_SENSOR_KIND, CFG_DATA_W'(kind));
    write_setting(REG_OFFSET, offset);
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      lo = 8'($urandom);
      case ($urandom_range(3))
        0: hi = 8'hFF;
        1: hi = 8'h00;
        default: hi = 8'($urandom);
      endcase
      remain = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(16));
      case ($urandom_range(9))
        7: begin
          // truncated frame, the next frame start drops it
          send_pad_byte(lo, 1'b1);
          repeat ($urandom_range(7)) send_pad_byte(8'($urandom), 1'b0);
        end
        8: begin
          repeat ($urandom_range(1, 5)) send_pad_byte(8'($urandom), 1'($urandom));
        end
        default: begin
          send_frame(lo, hi, remain, $urandom_range(7) != 0, 1'b1);
          if ($urandom_range(4) == 0) begin
            repeat ($urandom_range(1, 3)) send_pad_byte(8'($urandom), 1'b0);
          end
        end
      endcase
    end
    wait_idle();
  endtask

  task automatic test_receiver_hold();
    write_setting(REG_SENSOR_KIND, CFG_DATA_W'(KIND_12BIT));
    write_setting(REG_OFFSET, 12'($urandom));
    hold_req = 80;
    repeat (5) send_frame(8'($urandom), 8'($urandom), 8'($urandom), 1'b1, 1'b1);
    wait_idle();
  endtask

  // result side: random stalls, long hold on request, and the check
  always @(posedge clk) begin
    reading_t got;
    reading_t want;
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
    if (rst_n && out_tvalid && out_tready) begin
      got.temp = out_tdata;
      got.good = out_tuser;
      if (expected_readings.size() == 0) begin
        if (error_count < MAX_REPORTS) begin
          $display("unexpected reading: temp %0d crc_good %0b", got.temp, got.good);
        end
        error_count++;
      end else begin
        want = expected_readings.pop_front();
        if (got != want) begin
          if (error_count < MAX_REPORTS) begin
            $display("reading mismatch: expected temp %0d crc_good %0b, got temp %0d crc_good %0b",
                     want.temp, want.good, got.temp, got.good);
          end
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", quiet_cycles);
      $display("testbench: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_idle_pct = 36;
    rx_idle_pct = 64;
    test_first_frame_without_start();
    test_restart_mid_frame();
    test_saturation();
    test_half_degree();
    test_random_frames(KIND_12BIT, 12'h000, 75);
    test_random_frames(KIND_9BIT, 12'h7FF, 75);

    tx_idle_pct = 64;
    rx_idle_pct = 36;
    test_random_frames(KIND_12BIT, 12'h800, 75);
    test_random_frames(KIND_9BIT, 12'($urandom), 75);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_frames(KIND_9BIT, 12'h800, 75);
    test_receiver_hold();
    test_random_frames(KIND_12BIT, 12'($urandom), 75);

    wait_idle();
    if (error_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
